@@ hw/rtl/tcgr_pkg.sv @@
// Shared types, constants and font table for the text cell glyph renderer
`timescale 1ns / 1ps
`default_nettype none
package tcgr_pkg;

    localparam int PANEL_WIDTH_DEF  = 240;
    localparam int PANEL_HEIGHT_DEF = 240;
    localparam int MAX_CELLS_DEF    = 16;

    localparam int CELL_IDX_W  = 4;
    localparam int CELL_COLS   = 6;
    localparam int CELL_ROWS   = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int ROW_W       = 12;
    localparam int GEO_W       = 14;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X   = 2'd0,
        CFG_ORIGIN_Y   = 2'd1,
        CFG_CELL_COUNT = 2'd2,
        CFG_SCALE      = 2'd3
    } t_cfg_idx;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] t_glyph;

    typedef struct packed {
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [4:0] cell_count;
        logic [1:0] scale;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  win_left;
        logic [7:0]  win_top;
        logic [7:0]  win_right;
        logic [7:0]  win_bottom;
        t_glyph      glyph;
        logic [15:0] fore;
        logic [15:0] back;
        logic        dbl;
    } t_job;

    function automatic t_glyph glyph_cols(input logic [6:0] c0, input logic [6:0] c1,
                                          input logic [6:0] c2, input logic [6:0] c3,
                                          input logic [6:0] c4);
        t_glyph g;
        g[0] = c0;
        g[1] = c1;
        g[2] = c2;
        g[3] = c3;
        g[4] = c4;
        return g;
    endfunction

    function automatic t_glyph font_glyph(input logic [7:0] code);
        t_glyph g;
        case (code)
            8'h43:   g = glyph_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
            8'h50:   g = glyph_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
            8'h55:   g = glyph_cols(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
            8'h56:   g = glyph_cols(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
            8'h59:   g = glyph_cols(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
            8'h5A:   g = glyph_cols(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
            8'h58:   g = glyph_cols(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
            8'h2D:   g = glyph_cols(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
            8'h2E:   g = glyph_cols(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
            8'h41:   g = glyph_cols(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
            8'h42:   g = glyph_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
            8'h44:   g = glyph_cols(7'h7F, 7'h41, 7'h41, 7'h41, 7'h3E);
            8'h45:   g = glyph_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
            8'h46:   g = glyph_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
            8'h47:   g = glyph_cols(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
            8'h48:   g = glyph_cols(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
            8'h49:   g = glyph_cols(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
            8'h4B:   g = glyph_cols(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
            8'h4C:   g = glyph_cols(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
            8'h4D:   g = glyph_cols(7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F);
            8'h4E:   g = glyph_cols(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
            8'h4F:   g = glyph_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
            8'h52:   g = glyph_cols(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
            8'h53:   g = glyph_cols(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
            8'h54:   g = glyph_cols(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
            8'h57:   g = glyph_cols(7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F);
            8'h30:   g = glyph_cols(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
            8'h31:   g = glyph_cols(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
            8'h32:   g = glyph_cols(7'h62, 7'h51, 7'h49, 7'h49, 7'h46);
            8'h33:   g = glyph_cols(7'h22, 7'h41, 7'h49, 7'h49, 7'h36);
            8'h34:   g = glyph_cols(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
            8'h35:   g = glyph_cols(7'h2F, 7'h49, 7'h49, 7'h49, 7'h31);
            8'h36:   g = glyph_cols(7'h3E, 7'h49, 7'h49, 7'h49, 7'h30);
            8'h37:   g = glyph_cols(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
            8'h38:   g = glyph_cols(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
            8'h39:   g = glyph_cols(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/text_cell_glyph_renderer_top.sv @@
// Top level of the text cell glyph renderer: config registers, front end, queue, back end
//
// Usage:
//   Configuration: write origin_x, origin_y, cell_count and scale through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no cell is in flight.
//   Input channel (i_valid / o_ready): one beat per text cell. A cell that is
//   out of range, or any cell under bad geometry, is dropped with no output.
//   Output channel (o_valid / i_ready): a redrawn cell gives one window beat,
//   then 7 rows at scale 1 or 14 rows at scale 2; o_run_last marks the last.
//   The cell's job goes into the queue, then into the output register as the
//   window beat once the row generator is free. The row generator emits one
//   beat per cycle while i_ready is high, so a redrawn cell holds it for its
//   window beat and all its rows; cells that need no redraw never reach it.
//   A two-entry job queue lets the front end take cells back to back while
//   the row generator is busy; o_ready drops when the queue is full.
//   A stalled receiver holds the output register and, in turn, the queue.
//   Reset (synchronous, active low) clears the drawn-cell store, committed
//   colors and field state, empties the queue and sets scale to 1.
`timescale 1ns / 1ps
`default_nettype none
module text_cell_glyph_renderer_top #(
    parameter int PANEL_WIDTH  = tcgr_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = tcgr_pkg::PANEL_HEIGHT_DEF,
    parameter int MAX_CELLS    = tcgr_pkg::MAX_CELLS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_cell_index,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [15:0] i_fore_color,
    input  wire logic [15:0] i_back_color,
    input  wire logic        i_update_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_item_kind,
    output logic [7:0]       o_win_left,
    output logic [7:0]       o_win_top,
    output logic [7:0]       o_win_right,
    output logic [7:0]       o_win_bottom,
    output logic [11:0]      o_row_pattern,
    output logic [15:0]      o_row_fore,
    output logic [15:0]      o_row_back,
    output logic             o_run_last
);
    import tcgr_pkg::*;

    t_cfg r_cfg;
    logic w_push_valid;
    logic w_push_ready;
    t_job w_push_job;
    logic w_pop;
    logic w_pop_valid;
    t_job w_pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= 8'd0;
            r_cfg.origin_y   <= 8'd0;
            r_cfg.cell_count <= 5'd0;
            r_cfg.scale      <= 2'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:   r_cfg.origin_x   <= i_cfg_data;
                CFG_ORIGIN_Y:   r_cfg.origin_y   <= i_cfg_data;
                CFG_CELL_COUNT: r_cfg.cell_count <= i_cfg_data[4:0];
                CFG_SCALE:      r_cfg.scale      <= i_cfg_data[1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    tcgr_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_CELLS    (MAX_CELLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_index (i_cell_index),
        .i_char_code  (i_char_code),
        .i_fore_color (i_fore_color),
        .i_back_color (i_back_color),
        .i_update_end (i_update_end),
        .i_push_ready (w_push_ready),
        .o_push_valid (w_push_valid),
        .o_push_job   (w_push_job)
    );

    tcgr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_valid),
        .i_push_job   (w_push_job),
        .o_push_ready (w_push_ready),
        .i_pop        (w_pop),
        .o_pop_valid  (w_pop_valid),
        .o_pop_job    (w_pop_job)
    );

    tcgr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (w_pop_valid),
        .i_job         (w_pop_job),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_item_kind   (o_item_kind),
        .o_win_left    (o_win_left),
        .o_win_top     (o_win_top),
        .o_win_right   (o_win_right),
        .o_win_bottom  (o_win_bottom),
        .o_row_pattern (o_row_pattern),
        .o_row_fore    (o_row_fore),
        .o_row_back    (o_row_back),
        .o_run_last    (o_run_last)
    );

endmodule
`default_nettype wire

@@ hw/rtl/tcgr_front.sv @@
// Front end: accept cell beats, check geometry, track drawn cells and queue redraw jobs
`timescale 1ns / 1ps
`default_nettype none
module tcgr_front #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 240,
    parameter int MAX_CELLS    = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tcgr_pkg::t_cfg        i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [3:0]            i_cell_index,
    input  wire logic [7:0]            i_char_code,
    input  wire logic [15:0]           i_fore_color,
    input  wire logic [15:0]           i_back_color,
    input  wire logic                  i_update_end,
    input  wire logic                  i_push_ready,
    output logic                       o_push_valid,
    output tcgr_pkg::t_job             o_push_job
);
    import tcgr_pkg::*;

    localparam int STORE_DEPTH = (MAX_CELLS < (1 << CELL_IDX_W)) ? MAX_CELLS
                                                                   : (1 << CELL_IDX_W);
    localparam int SIDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0]        r_cell_chars [STORE_DEPTH];
    logic [15:0]       r_cfore;
    logic [15:0]       r_cback;
    logic              r_field_ready;

    logic              w_dbl;
    logic              w_scale_ok;
    logic [GEO_W-1:0]  w_span6;
    logic [GEO_W-1:0]  w_span;
    logic [GEO_W-1:0]  w_height_g;
    logic              w_geom_ok;
    logic              w_in_range;
    logic [SIDX_W-1:0] w_idx;
    logic              w_redraw;
    logic              w_act;
    logic [7:0]        w_off6;
    logic [7:0]        w_left;
    logic [7:0]        w_width;
    logic [7:0]        w_height;

    always_comb begin
        w_dbl      = (i_cfg.scale == 2'd2);
        w_scale_ok = (i_cfg.scale == 2'd1) || (i_cfg.scale == 2'd2);
        w_span6    = GEO_W'(i_cfg.cell_count) * GEO_W'(CELL_COLS);
        w_span     = w_dbl ? (w_span6 << 1) : w_span6;
        w_height_g = w_dbl ? GEO_W'(2 * CELL_ROWS) : GEO_W'(CELL_ROWS);
        w_geom_ok  = (i_cfg.cell_count != 5'd0)
                  && (GEO_W'(i_cfg.cell_count) <= GEO_W'(MAX_CELLS))
                  && w_scale_ok
                  && (GEO_W'(i_cfg.origin_x) + w_span <= GEO_W'(PANEL_WIDTH))
                  && (GEO_W'(i_cfg.origin_y) + w_height_g <= GEO_W'(PANEL_HEIGHT));
        w_in_range = {1'b0, i_cell_index} < i_cfg.cell_count;
        w_idx      = SIDX_W'(i_cell_index);
        w_redraw   = !r_field_ready || (i_fore_color != r_cfore)
                  || (i_back_color != r_cback) || (r_cell_chars[w_idx] != i_char_code);

        o_ready      = i_push_ready;
        w_act        = i_valid && o_ready && w_geom_ok && w_in_range;
        o_push_valid = w_act && w_redraw;

        w_off6   = 8'(i_cell_index) * 8'(CELL_COLS);
        w_left   = i_cfg.origin_x + (w_dbl ? (w_off6 << 1) : w_off6);
        w_width  = w_dbl ? 8'(2 * CELL_COLS) : 8'(CELL_COLS);
        w_height = w_dbl ? 8'(2 * CELL_ROWS) : 8'(CELL_ROWS);

        o_push_job.win_left   = w_left;
        o_push_job.win_top    = i_cfg.origin_y;
        o_push_job.win_right  = w_left + w_width - 8'd1;
        o_push_job.win_bottom = i_cfg.origin_y + w_height - 8'd1;
        o_push_job.glyph      = font_glyph(i_char_code);
        o_push_job.fore       = i_fore_color;
        o_push_job.back       = i_back_color;
        o_push_job.dbl        = w_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_cell_chars[i] <= 8'd0;
            end
            r_cfore       <= 16'd0;
            r_cback       <= 16'd0;
            r_field_ready <= 1'b0;
        end else if (w_act) begin
            if (w_redraw) begin
                r_cell_chars[w_idx] <= i_char_code;
            end
            if (i_update_end) begin
                r_cfore       <= i_fore_color;
                r_cback       <= i_back_color;
                r_field_ready <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tcgr_queue.sv @@
// Short job queue between the front end and the row generator
`timescale 1ns / 1ps
`default_nettype none
module tcgr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tcgr_pkg::t_job i_push_job,
    output logic                o_push_ready,
    input  wire logic           i_pop,
    output logic                o_pop_valid,
    output tcgr_pkg::t_job      o_pop_job
);
    import tcgr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
        o_pop_valid  = (r_count != '0);
        o_pop_job    = r_mem[r_rd];
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tcgr_back.sv @@
// Back end: emit the window beat and the scaled pixel rows of each queued job
`timescale 1ns / 1ps
`default_nettype none
module tcgr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_pop_valid,
    input  wire tcgr_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_item_kind,
    output logic [7:0]          o_win_left,
    output logic [7:0]          o_win_top,
    output logic [7:0]          o_win_right,
    output logic [7:0]          o_win_bottom,
    output logic [11:0]         o_row_pattern,
    output logic [15:0]         o_row_fore,
    output logic [15:0]         o_row_back,
    output logic                o_run_last
);
    import tcgr_pkg::*;

    function automatic logic [ROW_W-1:0] row_bits(input t_glyph g, input logic [3:0] row,
                                                   input logic dbl);
        logic [ROW_W-1:0] pat;
        logic [2:0]       bit_idx;
        int               gc;
        pat     = '0;
        bit_idx = dbl ? row[3:1] : row[2:0];
        for (int c = 0; c < ROW_W; c++) begin
            gc = dbl ? (c >> 1) : c;
            if (gc < GLYPH_COLS) begin
                pat[c] = g[gc][bit_idx];
            end
        end
        return pat;
    endfunction

    t_job             r_job;
    logic             r_active;
    logic [3:0]       r_row;
    logic             r_valid;
    logic             r_kind;
    logic [7:0]       r_win_left;
    logic [7:0]       r_win_top;
    logic [7:0]       r_win_right;
    logic [7:0]       r_win_bottom;
    logic [ROW_W-1:0] r_pattern;
    logic [15:0]      r_fore;
    logic [15:0]      r_back;
    logic             r_last;

    t_job             n_job;
    logic             n_active;
    logic [3:0]       n_row;
    logic             n_valid;
    logic             n_kind;
    logic [7:0]       n_win_left;
    logic [7:0]       n_win_top;
    logic [7:0]       n_win_right;
    logic [7:0]       n_win_bottom;
    logic [ROW_W-1:0] n_pattern;
    logic [15:0]      n_fore;
    logic [15:0]      n_back;
    logic             n_last;

    logic             w_free;
    logic             w_last_row;

    always_comb begin
        w_free     = !r_valid || i_ready;
        w_last_row = (r_row == (r_job.dbl ? 4'(2 * CELL_ROWS - 1) : 4'(CELL_ROWS - 1)));

        o_pop        = 1'b0;
        n_job        = r_job;
        n_active     = r_active;
        n_row        = r_row;
        n_valid      = r_valid;
        n_kind       = r_kind;
        n_win_left   = r_win_left;
        n_win_top    = r_win_top;
        n_win_right  = r_win_right;
        n_win_bottom = r_win_bottom;
        n_pattern    = r_pattern;
        n_fore       = r_fore;
        n_back       = r_back;
        n_last       = r_last;

        if (w_free) begin
            n_valid = 1'b0;
            if (r_active) begin
                n_valid      = 1'b1;
                n_kind       = KIND_ROW;
                n_win_left   = 8'd0;
                n_win_top    = 8'd0;
                n_win_right  = 8'd0;
                n_win_bottom = 8'd0;
                n_pattern    = row_bits(r_job.glyph, r_row, r_job.dbl);
                n_fore       = r_job.fore;
                n_back       = r_job.back;
                n_last       = w_last_row;
                n_row        = r_row + 4'd1;
                if (w_last_row) begin
                    n_active = 1'b0;
                end
            end else if (i_pop_valid) begin
                o_pop        = 1'b1;
                n_job        = i_job;
                n_active     = 1'b1;
                n_row        = 4'd0;
                n_valid      = 1'b1;
                n_kind       = KIND_WINDOW;
                n_win_left   = i_job.win_left;
                n_win_top    = i_job.win_top;
                n_win_right  = i_job.win_right;
                n_win_bottom = i_job.win_bottom;
                n_pattern    = '0;
                n_fore       = 16'd0;
                n_back       = 16'd0;
                n_last       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_row        <= n_row;
        r_kind       <= n_kind;
        r_win_left   <= n_win_left;
        r_win_top    <= n_win_top;
        r_win_right  <= n_win_right;
        r_win_bottom <= n_win_bottom;
        r_pattern    <= n_pattern;
        r_fore       <= n_fore;
        r_back       <= n_back;
        r_last       <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_item_kind   = r_kind;
    assign o_win_left    = r_win_left;
    assign o_win_top     = r_win_top;
    assign o_win_right   = r_win_right;
    assign o_win_bottom  = r_win_bottom;
    assign o_row_pattern = r_pattern;
    assign o_row_fore    = r_fore;
    assign o_row_back    = r_back;
    assign o_run_last    = r_last;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the text cell glyph renderer: directed and random cell traffic
`timescale 1ns / 1ps
module tb_top;
    import tcgr_pkg::*;

    localparam int PANEL_W    = 240;
    localparam int PANEL_H    = 240;
    localparam int CELLS_MAX  = 16;
    localparam int IDLE_PAUSE = 24;
    localparam int N_ITEMS    = 230;
    localparam string FONT_CHARS = "CPUVYZX-.ABDEFGHIKLMNORSTW0123456789 ";

    typedef struct packed {
        logic [3:0]  idx;
        logic [7:0]  code;
        logic [15:0] fore;
        logic [15:0] back;
        logic        upd_end;
    } t_text_beat;

    typedef struct packed {
        logic        kind;
        logic [7:0]  left;
        logic [7:0]  top;
        logic [7:0]  right;
        logic [7:0]  bottom;
        logic [11:0] pattern;
        logic [15:0] fore;
        logic [15:0] back;
        logic        run_last;
    } t_pix_beat;

    typedef logic [0:4][7:0] t_glyph_cols;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_ORIGIN_X;
    logic [7:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        dut_ready;
    logic [3:0]  in_idx = '0;
    logic [7:0]  in_code = '0;
    logic [15:0] in_fore = '0;
    logic [15:0] in_back = '0;
    logic        in_upd_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_left, o_top, o_right, o_bottom;
    logic [11:0] o_pattern;
    logic [15:0] o_fore, o_back;
    logic        o_last;

    t_text_beat  text_q[$];
    t_pix_beat   drawn_q[$];
    t_text_beat  cur_beat;

    // predictor state and register copy
    int          cfg_ox, cfg_oy, cfg_count, cfg_scale;
    logic [7:0]  shown_chars [CELLS_MAX];
    logic [15:0] comm_fore, comm_back;
    logic        field_ready;

    int n_pushed, n_taken, n_effective, n_redraws, n_settings;
    int n_win, n_rows, n_errors;
    int send_gap, recv_stall;
    bit send_idle_en, recv_idle_en;

    text_cell_glyph_renderer_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_ready      (dut_ready),
        .i_cell_index (in_idx),
        .i_char_code  (in_code),
        .i_fore_color (in_fore),
        .i_back_color (in_back),
        .i_update_end (in_upd_end),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_item_kind  (o_kind),
        .o_win_left   (o_left),
        .o_win_top    (o_top),
        .o_win_right  (o_right),
        .o_win_bottom (o_bottom),
        .o_row_pattern(o_pattern),
        .o_row_fore   (o_fore),
        .o_row_back   (o_back),
        .o_run_last   (o_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_glyph_cols glyph_of(input logic [7:0] code);
        t_glyph_cols g;
        case (code)
            8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'h4D: g = {8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
            8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'h32: g = {8'h62, 8'h51, 8'h49, 8'h49, 8'h46};
            8'h33: g = {8'h22, 8'h41, 8'h49, 8'h49, 8'h36};
            8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'h35: g = {8'h2F, 8'h49, 8'h49, 8'h49, 8'h31};
            8'h36: g = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h30};
            8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic bit geometry_ok();
        if (cfg_count == 0 || cfg_count > CELLS_MAX) return 1'b0;
        if (cfg_scale == 0 || cfg_scale > 2) return 1'b0;
        if (cfg_ox + cfg_count * 6 * cfg_scale > PANEL_W) return 1'b0;
        if (cfg_oy + 7 * cfg_scale > PANEL_H) return 1'b0;
        return 1'b1;
    endfunction

    // work out the window and pixel-row beats that one accepted cell causes
    task automatic render_cell(input t_text_beat t);
        t_glyph_cols cols;
        t_pix_beat   pb;
        int          w, h, left, bit_n, gc;
        logic [11:0] pat;
        if (!geometry_ok() || t.idx >= cfg_count) return;
        n_effective++;
        if (!field_ready || t.fore != comm_fore || t.back != comm_back ||
            shown_chars[t.idx] != t.code) begin
            cols = glyph_of(t.code);
            w = 6 * cfg_scale;
            h = 7 * cfg_scale;
            left = cfg_ox + t.idx * w;
            pb = '0;
            pb.kind = KIND_WINDOW;
            pb.left = left[7:0];
            pb.top = cfg_oy[7:0];
            pb.right = 8'(left + w - 1);
            pb.bottom = 8'(cfg_oy + h - 1);
            drawn_q.push_back(pb);
            for (int r = 0; r < h; r++) begin
                pat = '0;
                bit_n = r / cfg_scale;
                for (int c = 0; c < w; c++) begin
                    gc = c / cfg_scale;
                    if (gc < 5 && cols[gc][bit_n]) pat[c] = 1'b1;
                end
                pb = '0;
                pb.kind = KIND_ROW;
                pb.pattern = pat;
                pb.fore = t.fore;
                pb.back = t.back;
                pb.run_last = (r == h - 1);
                drawn_q.push_back(pb);
            end
            shown_chars[t.idx] = t.code;
            n_redraws++;
        end
        if (t.upd_end) begin
            comm_fore = t.fore;
            comm_back = t.back;
            field_ready = 1'b1;
        end
    endtask

    task automatic note_error(input string what, input t_pix_beat exp_b, input t_pix_beat got);
        n_errors++;
        if (n_errors <= 10) begin
            $display("[%0t] %s", $realtime, what);
            $display("    exp kind=%0d win=%0d,%0d,%0d,%0d pat=%03h fg=%04h bg=%04h last=%0d",
                     exp_b.kind, exp_b.left, exp_b.top, exp_b.right, exp_b.bottom,
                     exp_b.pattern, exp_b.fore, exp_b.back, exp_b.run_last);
            $display("    got kind=%0d win=%0d,%0d,%0d,%0d pat=%03h fg=%04h bg=%04h last=%0d",
                     got.kind, got.left, got.top, got.right, got.bottom,
                     got.pattern, got.fore, got.back, got.run_last);
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && dut_ready) begin
                render_cell(cur_beat);
                n_taken++;
            end
            if (!in_valid || dut_ready) begin
                if (send_gap > 0 || text_q.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    in_valid <= 1'b0;
                end else begin
                    cur_beat = text_q.pop_front();
                    in_idx <= cur_beat.idx;
                    in_code <= cur_beat.code;
                    in_fore <= cur_beat.fore;
                    in_back <= cur_beat.back;
                    in_upd_end <= cur_beat.upd_end;
                    in_valid <= 1'b1;
                    if (send_idle_en && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 10);
                end
            end
        end
    end

    always @(posedge clk) begin
        t_pix_beat got, exp_b;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                got = {o_kind, o_left, o_top, o_right, o_bottom,
                       o_pattern, o_fore, o_back, o_last};
                if (got.kind == KIND_WINDOW) n_win++;
                else n_rows++;
                if (drawn_q.size() == 0) begin
                    note_error("output beat with nothing expected", '0, got);
                end else begin
                    exp_b = drawn_q.pop_front();
                    if (got.kind != exp_b.kind || got.left != exp_b.left ||
                        got.top != exp_b.top || got.right != exp_b.right ||
                        got.bottom != exp_b.bottom || got.pattern != exp_b.pattern ||
                        got.fore != exp_b.fore || got.back != exp_b.back ||
                        got.run_last != exp_b.run_last)
                        note_error("output beat mismatch", exp_b, got);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (recv_idle_en && $urandom_range(0, 7) == 0)
                    recv_stall = $urandom_range(1, 10);
            end
        end
    end

    task automatic wait_idle();
        do @(posedge clk); while (n_taken != n_pushed || drawn_q.size() != 0);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:   cfg_ox = value & 8'hFF;
            CFG_ORIGIN_Y:   cfg_oy = value & 8'hFF;
            CFG_CELL_COUNT: cfg_count = value & 5'h1F;
            CFG_SCALE:      cfg_scale = value & 2'h3;
            default: ;
        endcase
        n_settings++;
    endtask

    task automatic send_text(input int idx, input logic [7:0] code, input logic [15:0] fore,
                             input logic [15:0] back, input bit upd_end);
        t_text_beat t;
        t = '{idx: idx[3:0], code: code, fore: fore, back: back, upd_end: upd_end};
        text_q.push_back(t);
        n_pushed++;
    endtask

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 9) < 7)
            return FONT_CHARS[$urandom_range(0, FONT_CHARS.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0]  line_chars [CELLS_MAX];
        logic [15:0] fg, bg;
        int          sc, cnt, n_upd;

        cfg_ox = 0;
        cfg_oy = 0;
        cfg_count = 0;
        cfg_scale = 1;
        foreach (shown_chars[i]) shown_chars[i] = '0;
        comm_fore = '0;
        comm_back = '0;
        field_ready = 1'b0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // field disabled after reset
        send_text(0, 8'h41, 16'hFFFF, 16'h0000, 1'b1);
        write_reg(CFG_ORIGIN_X, 0);
        write_reg(CFG_ORIGIN_Y, 0);
        write_reg(CFG_CELL_COUNT, 16);
        write_reg(CFG_SCALE, 1);
        send_text(0, 8'h41, 16'hFFFF, 16'h0000, 1'b0);
        send_text(15, 8'hFF, 16'hFFFF, 16'h0000, 1'b0);
        send_text(1, 8'h00, 16'hFFFF, 16'h0000, 1'b0);
        send_text(2, 8'h7F, 16'hFFFF, 16'h0000, 1'b0);
        send_text(3, 8'h2E, 16'hFFFF, 16'h0000, 1'b0);
        send_text(4, 8'h2D, 16'hFFFF, 16'h0000, 1'b1);
        send_text(0, 8'h41, 16'hFFFF, 16'h0000, 1'b0);
        send_text(1, 8'h00, 16'hFFFF, 16'h0000, 1'b0);
        send_text(0, 8'h41, 16'hFFFE, 16'h0000, 1'b0);
        send_text(0, 8'h42, 16'hFFFF, 16'h0000, 1'b1);
        send_text(5, 8'h80, 16'h0000, 16'hFFFF, 1'b1);
        write_reg(CFG_CELL_COUNT, 5);
        send_text(7, 8'h5A, 16'h1234, 16'h4321, 1'b1);
        send_text(4, 8'h39, 16'h0000, 16'hFFFF, 1'b0);
        write_reg(CFG_SCALE, 2);
        write_reg(CFG_CELL_COUNT, 16);
        write_reg(CFG_ORIGIN_X, 48);
        write_reg(CFG_ORIGIN_Y, 226);
        send_text(15, 8'h57, 16'h5555, 16'hAAAA, 1'b0);
        send_text(0, 8'h38, 16'h5555, 16'hAAAA, 1'b1);
        // each of these settings breaks the geometry
        write_reg(CFG_ORIGIN_X, 49);
        send_text(0, 8'h4D, 16'h0F0F, 16'hF0F0, 1'b1);
        write_reg(CFG_ORIGIN_X, 48);
        write_reg(CFG_ORIGIN_Y, 227);
        send_text(1, 8'h4D, 16'h0F0F, 16'hF0F0, 1'b1);
        write_reg(CFG_ORIGIN_Y, 226);
        write_reg(CFG_SCALE, 3);
        send_text(2, 8'h4D, 16'h0F0F, 16'hF0F0, 1'b1);
        write_reg(CFG_SCALE, 0);
        send_text(3, 8'h4D, 16'h0F0F, 16'hF0F0, 1'b1);
        write_reg(CFG_SCALE, 1);
        write_reg(CFG_CELL_COUNT, 17);
        send_text(4, 8'h4D, 16'h0F0F, 16'hF0F0, 1'b1);
        write_reg(CFG_CELL_COUNT, 31);
        send_text(5, 8'h4D, 16'h0F0F, 16'hF0F0, 1'b1);
        write_reg(CFG_CELL_COUNT, 16);
        write_reg(CFG_ORIGIN_X, 144);
        write_reg(CFG_ORIGIN_Y, 233);
        send_text(15, 8'h58, 16'h5555, 16'hAAAA, 1'b0);

        while (n_pushed < N_ITEMS) begin
            if (n_pushed >= N_ITEMS - 40) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end else begin
                send_idle_en = $urandom_range(0, 3) != 0;
                recv_idle_en = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_CELL_COUNT, $urandom_range(0, 255));
                write_reg(CFG_SCALE, $urandom_range(0, 255));
                write_reg(CFG_ORIGIN_X, $urandom_range(0, 255));
                write_reg(CFG_ORIGIN_Y, $urandom_range(0, 255));
            end else begin
                sc = $urandom_range(1, 2);
                cnt = $urandom_range(1, 16);
                write_reg(CFG_CELL_COUNT, cnt);
                write_reg(CFG_SCALE, sc);
                write_reg(CFG_ORIGIN_X, $urandom_range(0, PANEL_W - cnt * 6 * sc));
                write_reg(CFG_ORIGIN_Y, $urandom_range(0, PANEL_H - 7 * sc));
            end
            cnt = (cfg_count > 0 && cfg_count <= CELLS_MAX) ? cfg_count : 4;
            fg = 16'($urandom);
            bg = 16'($urandom);
            foreach (line_chars[i]) line_chars[i] = pick_code();
            n_upd = $urandom_range(2, 4);
            for (int u = 0; u < n_upd && n_pushed < N_ITEMS; u++) begin
                if ($urandom_range(0, 3) == 0) begin
                    fg = 16'($urandom);
                    bg = 16'($urandom);
                end
                for (int i = 0; i < cnt; i++)
                    if ($urandom_range(0, 9) < 3) line_chars[i] = pick_code();
                for (int i = 0; i < cnt && n_pushed < N_ITEMS; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_text($urandom_range(0, 15), 8'($urandom_range(0, 255)),
                                  16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
                    send_text(i, line_chars[i], fg, bg,
                              i == cnt - 1 && $urandom_range(0, 7) != 0);
                end
                if ($urandom_range(0, 3) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (drawn_q.size() != 0) n_errors += drawn_q.size();
        $display("Sent %0d text beats (%0d in range, %0d redrawn) across %0d register writes",
                 n_taken, n_effective, n_redraws, n_settings);
        $display("Checked %0d window beats and %0d pixel-row beats, %0d errors",
                 n_win, n_rows, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d beats still expected", drawn_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_front.sv
hw/rtl/tcgr_queue.sv
hw/rtl/tcgr_back.sv
hw/rtl/text_cell_glyph_renderer_top.sv
tb/tb_top.sv
